/* hdl/tdt_pkg.sv */
package tdt_pkg;

	// table geometry
	localparam int ENTRIES = 8;
	localparam int IDX_W   = $clog2(ENTRIES);

	// command codes
	localparam logic [2:0] CMD_REPORT = 3'd0;
	localparam logic [2:0] CMD_SELECT = 3'd1;
	localparam logic [2:0] CMD_OPEN   = 3'd2;
	localparam logic [2:0] CMD_CLOSE  = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [47:0] mac_addr;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [2:0]  slot;
		logic        hit;
		logic        evicted;
		logic [31:0] first_seen;
		logic [31:0] report_total;
		logic        selection_valid;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic cap;
		logic look;
		logic scan_step;
		logic apply;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_report;
		logic any_hit;
		logic any_free;
		logic scan_last;
	} dp_stat_t;

endpackage

/* hdl/tdt_dp.sv */
module tdt_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  tdt_pkg::req_t     req,
	input  tdt_pkg::dp_cmd_t  ctl,
	output tdt_pkg::dp_stat_t stat,
	output tdt_pkg::rsp_t     rsp
);

	// table storage; only the valid bits are reset
	logic [tdt_pkg::ENTRIES-1:0] valid_q;
	logic [47:0]                 addr_q  [tdt_pkg::ENTRIES];
	logic [31:0]                 first_q [tdt_pkg::ENTRIES];
	logic [31:0]                 last_q  [tdt_pkg::ENTRIES];

	logic [31:0] seq_q;
	logic [31:0] rpt_q;
	logic        has_sel_q;
	logic        has_det_q;
	logic [47:0] sel_addr_q;
	logic [47:0] det_addr_q;

	tdt_pkg::req_t             item_q;
	logic [tdt_pkg::IDX_W-1:0] idx_q;
	logic [tdt_pkg::IDX_W-1:0] best_q;
	logic [31:0]               best_time_q;
	logic                      found_q;
	logic                      hit_q;
	logic                      evict_q;
	tdt_pkg::rsp_t             rsp_q;
	tdt_pkg::rsp_t             rsp_d;

	logic                      any_hit;
	logic                      any_free;
	logic [tdt_pkg::IDX_W-1:0] hit_idx;
	logic [tdt_pkg::IDX_W-1:0] free_idx;
	logic                      is_report;
	logic                      scan_last;
	logic                      scan_pinned;
	logic                      scan_take;
	logic [tdt_pkg::IDX_W-1:0] next_best;
	logic [31:0]               seq_next;

	assign is_report = (item_q.cmd == tdt_pkg::CMD_REPORT);
	assign scan_last = (idx_q == tdt_pkg::IDX_W'(tdt_pkg::ENTRIES - 1));
	assign seq_next  = seq_q + 32'd1;

	// match and free search, lowest index wins
	always_comb begin
		any_hit  = 1'b0;
		hit_idx  = '0;
		any_free = 1'b0;
		free_idx = '0;
		for (int i = tdt_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && addr_q[i] == item_q.mac_addr) begin
				any_hit = 1'b1;
				hit_idx = tdt_pkg::IDX_W'(i);
			end
			if (!valid_q[i]) begin
				any_free = 1'b1;
				free_idx = tdt_pkg::IDX_W'(i);
			end
		end
	end

	// victim candidate at the scan index
	always_comb begin
		if (has_det_q) begin
			scan_pinned = (addr_q[idx_q] == det_addr_q);
		end else begin
			scan_pinned = has_sel_q && (addr_q[idx_q] == sel_addr_q);
		end
		scan_take = !scan_pinned && (!found_q || last_q[idx_q] < best_time_q);
		next_best = scan_take ? idx_q : best_q;
	end

	// result fields for the current item
	always_comb begin
		rsp_d                 = '0;
		rsp_d.report_total    = rpt_q;
		rsp_d.selection_valid = has_sel_q;
		case (item_q.cmd)
			tdt_pkg::CMD_REPORT: begin
				rsp_d.slot            = 3'(idx_q);
				rsp_d.hit             = hit_q;
				rsp_d.evicted         = evict_q;
				rsp_d.first_seen      = hit_q ? first_q[idx_q] : seq_next;
				rsp_d.report_total    = rpt_q + 32'd1;
				rsp_d.selection_valid = 1'b1;
			end
			tdt_pkg::CMD_SELECT: rsp_d.selection_valid = 1'b1;
			tdt_pkg::CMD_CLEAR: begin
				rsp_d.report_total    = '0;
				rsp_d.selection_valid = 1'b0;
			end
			default: ;
		endcase
	end

	assign stat.is_report = is_report;
	assign stat.any_hit   = any_hit;
	assign stat.any_free  = any_free;
	assign stat.scan_last = scan_last;
	assign rsp            = rsp_q;

	// control state: valid bits, counters, view flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			seq_q     <= '0;
			rpt_q     <= '0;
			has_sel_q <= 1'b0;
			has_det_q <= 1'b0;
		end else if (ctl.apply) begin
			case (item_q.cmd)
				tdt_pkg::CMD_REPORT: begin
					if (!hit_q) begin
						valid_q[idx_q] <= 1'b1;
						seq_q          <= seq_next;
					end
					rpt_q <= rpt_q + 32'd1;
					if (!has_sel_q && !has_det_q) begin
						has_sel_q <= 1'b1;
					end
				end
				tdt_pkg::CMD_SELECT: has_sel_q <= 1'b1;
				tdt_pkg::CMD_OPEN: begin
					if (has_sel_q) begin
						has_det_q <= 1'b1;
					end
				end
				tdt_pkg::CMD_CLOSE: has_det_q <= 1'b0;
				tdt_pkg::CMD_CLEAR: begin
					valid_q   <= '0;
					seq_q     <= '0;
					rpt_q     <= '0;
					has_sel_q <= 1'b0;
					has_det_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload: capture, lookup, scan, entry write and result
	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			item_q <= req;
		end
		if (ctl.look) begin
			if (is_report && !any_hit && !any_free) begin
				idx_q   <= '0;
				best_q  <= '0;
				found_q <= 1'b0;
				hit_q   <= 1'b0;
				evict_q <= 1'b1;
			end else begin
				idx_q   <= any_hit ? hit_idx : free_idx;
				hit_q   <= any_hit;
				evict_q <= 1'b0;
			end
		end
		// advance the victim scan, land on the winner at the last slot
		if (ctl.scan_step) begin
			if (scan_take) begin
				best_q      <= idx_q;
				best_time_q <= last_q[idx_q];
				found_q     <= 1'b1;
			end
			idx_q <= scan_last ? next_best : idx_q + tdt_pkg::IDX_W'(1);
		end
		if (ctl.apply) begin
			rsp_q <= rsp_d;
			case (item_q.cmd)
				tdt_pkg::CMD_REPORT: begin
					if (!hit_q) begin
						addr_q[idx_q]  <= item_q.mac_addr;
						first_q[idx_q] <= seq_next;
					end
					last_q[idx_q] <= item_q.now_ms;
					if (!has_sel_q && !has_det_q) begin
						sel_addr_q <= item_q.mac_addr;
					end
				end
				tdt_pkg::CMD_SELECT: sel_addr_q <= item_q.mac_addr;
				tdt_pkg::CMD_OPEN: begin
					if (has_sel_q) begin
						det_addr_q <= sel_addr_q;
					end
				end
				tdt_pkg::CMD_CLEAR: begin
					sel_addr_q <= '0;
					det_addr_q <= '0;
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a hit always points at a live entry
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.apply && is_report && hit_q) |-> valid_q[idx_q])
		else $error("hit on an empty slot");

	// eviction only happens on a full table
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.apply && is_report && evict_q) |-> (valid_q == '1))
		else $error("eviction with a free slot");

	// a report bumps the report count by one
	a_rpt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.apply && is_report) |=> (rpt_q == $past(rpt_q) + 32'd1))
		else $error("report count did not advance");
`endif

endmodule

/* hdl/tdt_ctrl.sv */
module tdt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  tdt_pkg::dp_stat_t stat,
	output tdt_pkg::dp_cmd_t  ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_SCAN,
		S_APPLY
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// datapath commands
	always_comb begin
		ctl.cap       = req_valid && (state_q == S_IDLE);
		ctl.look      = (state_q == S_LOOK);
		ctl.scan_step = (state_q == S_SCAN);
		ctl.apply     = (state_q == S_APPLY) && out_free;
	end

	// sequence one item; hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.apply) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (stat.is_report && !stat.any_hit && !stat.any_free) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_APPLY;
					end
				end
				S_SCAN: begin
					if (stat.scan_last) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// an accepted item goes straight to lookup
	a_cap_look: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_LOOK))
		else $error("accepted item not looked up");

	// the result register is never overwritten before its transfer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.apply |-> (!rsp_valid_q || !rsp_stall))
		else $error("result overwritten");

	// only a report runs the victim scan
	a_scan_report: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> stat.is_report)
		else $error("scan for a non-report command");
`endif

endmodule

/* hdl/tracked_device_table_lru_pinned_top.sv */
// channel | valid     | stall     | payload
// request | req_valid | req_stall | req (tdt_pkg::req_t)
// result  | rsp_valid | rsp_stall | rsp (tdt_pkg::rsp_t)
//
// One item at a time. A report that hits, or finds a free slot, and every
// other command pass through the lookup and apply states to the result register.
// A report that misses on a full table adds a victim scan between the two,
// one slot per cycle through a single read of the timestamp array.
// Reset empties the table and clears counters and the selection.
// A stalled result holds in its register; the next request is taken meanwhile.
module tracked_device_table_lru_pinned_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  tdt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tdt_pkg::rsp_t rsp
);

	tdt_pkg::dp_cmd_t  ctl;
	tdt_pkg::dp_stat_t stat;

	tdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	tdt_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
